>>> design/m3i_pkg.sv
// m3i_pkg: shared types and constants for the 3x3 matrix inverse block.
// Used by every module of the design; no dependencies.
package m3i_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int THR_WIDTH  = 32;
  localparam int THR_SCALE  = 32;              // threshold LSB is 2^-32
  localparam int NLANE      = 9;

  localparam int PW  = 2 * ELEM_WIDTH;         // element product
  localparam int CW  = 2 * ELEM_WIDTH + 1;     // cofactor
  localparam int LOW = CW - ELEM_WIDTH;        // cofactor split point for a*cof
  localparam int LW  = ELEM_WIDTH + LOW + 1;   // low partial product
  localparam int TW  = 3 * ELEM_WIDTH + 1;     // a*cof term
  localparam int DW  = 3 * ELEM_WIDTH + 2;     // determinant
  localparam int DNW = DW + 1;                 // divisor 2*|det|
  localparam int RW  = DW + ELEM_WIDTH + 2;    // divider remainder
  localparam int XW  = DW + 3 * FRAC_BITS + THR_SCALE;
  localparam int QW  = ELEM_WIDTH;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [ELEM_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic [ELEM_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] a00;
    logic signed [ELEM_WIDTH-1:0] a01;
    logic signed [ELEM_WIDTH-1:0] a02;
    logic signed [ELEM_WIDTH-1:0] a10;
    logic signed [ELEM_WIDTH-1:0] a11;
    logic signed [ELEM_WIDTH-1:0] a12;
    logic signed [ELEM_WIDTH-1:0] a20;
    logic signed [ELEM_WIDTH-1:0] a21;
    logic signed [ELEM_WIDTH-1:0] a22;
  } m3i_in_t;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] b00;
    logic signed [ELEM_WIDTH-1:0] b01;
    logic signed [ELEM_WIDTH-1:0] b02;
    logic signed [ELEM_WIDTH-1:0] b10;
    logic signed [ELEM_WIDTH-1:0] b11;
    logic signed [ELEM_WIDTH-1:0] b12;
    logic signed [ELEM_WIDTH-1:0] b20;
    logic signed [ELEM_WIDTH-1:0] b21;
    logic signed [ELEM_WIDTH-1:0] b22;
    logic                         singular;
    logic                         saturated;
  } m3i_out_t;

  // job handed from front to back: classified matrix, adjugate and |det|
  typedef struct packed {
    logic                       singular;
    logic                       det_neg;
    logic [DW-1:0]              det_abs;
    logic [NLANE-1:0][CW-1:0]   cof;
  } m3i_job_t;

endpackage

>>> design/m3i_front.sv
// m3i_front: cofactors, determinant and singular test, five register stages.
// Depends on m3i_pkg.
module m3i_front import m3i_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  m3i_in_t              in_word_i,
  input  logic [THR_WIDTH-1:0] thr_i,
  output logic                 job_valid_o,
  input  logic                 job_stall_i,
  output m3i_job_t             job_o
);

  localparam int NST = 5;
  // operand indexes of each cofactor: p*q - r*s, adjugate order
  localparam int unsigned CIDX [NLANE][4] = '{
    '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};

  logic signed [ELEM_WIDTH-1:0] a [NLANE];
  logic                         en;
  logic [NST-1:0]               v_q;

  logic signed [PW-1:0]         pp_q [NLANE];
  logic signed [PW-1:0]         pm_q [NLANE];
  logic signed [ELEM_WIDTH-1:0] s0_a_q [3];
  logic signed [ELEM_WIDTH-1:0] s1_a_q [3];
  logic signed [CW-1:0]         s1_cof_q [NLANE];
  logic signed [CW-1:0]         s2_cof_q [NLANE];
  logic signed [CW-1:0]         s3_cof_q [NLANE];
  logic signed [CW-1:0]         s4_cof_q [NLANE];
  logic signed [LW-1:0]         lo_q [3];
  logic signed [PW-1:0]         hi_q [3];
  logic signed [TW-1:0]         term_q [3];
  logic signed [DW-1:0]         det_q;
  logic [DW-1:0]                det_abs;

  always_comb begin
    a[0] = in_word_i.a00; a[1] = in_word_i.a01; a[2] = in_word_i.a02;
    a[3] = in_word_i.a10; a[4] = in_word_i.a11; a[5] = in_word_i.a12;
    a[6] = in_word_i.a20; a[7] = in_word_i.a21; a[8] = in_word_i.a22;
  end

  // whole front moves together; last stage drains into the queue
  assign en          = !v_q[NST-1] || !job_stall_i;
  assign in_stall_o  = !en;
  assign job_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        pp_q[l]     <= a[CIDX[l][0]] * a[CIDX[l][1]];
        pm_q[l]     <= a[CIDX[l][2]] * a[CIDX[l][3]];
        s1_cof_q[l] <= CW'(pp_q[l]) - CW'(pm_q[l]);
        s2_cof_q[l] <= s1_cof_q[l];
        s3_cof_q[l] <= s2_cof_q[l];
        s4_cof_q[l] <= s3_cof_q[l];
      end
      for (int k = 0; k < 3; k++) begin
        s0_a_q[k] <= a[3*k];
        s1_a_q[k] <= s0_a_q[k];
        // a * cof split in two products: a times the cofactor's high ELEM_WIDTH bits and a times its low LOW bits
        lo_q[k]   <= s1_a_q[k] * $signed({1'b0, s1_cof_q[k][LOW-1:0]});
        hi_q[k]   <= s1_a_q[k] * $signed(s1_cof_q[k][CW-1:LOW]);
        term_q[k] <= (TW'(hi_q[k]) <<< LOW) + TW'(lo_q[k]);
      end
      det_q <= DW'(term_q[0]) + DW'(term_q[1]) + DW'(term_q[2]);
    end
  end

  always_comb begin
    det_abs       = det_q[DW-1] ? (~det_q + 1'b1) : det_q;
    job_o.det_neg = det_q[DW-1];
    job_o.det_abs = det_abs;
    // |det| * 2^-3F <= T * 2^-32, scaled to integers
    job_o.singular = (XW'(det_abs) << THR_SCALE) <= (XW'(thr_i) << (3 * FRAC_BITS));
    for (int l = 0; l < NLANE; l++) begin
      job_o.cof[l] = s4_cof_q[l];
    end
  end

endmodule

>>> design/m3i_fifo.sv
// m3i_fifo: short job queue between the front and the back.
// Depends on m3i_pkg.
module m3i_fifo import m3i_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_valid_i,
  output logic     wr_stall_o,
  input  m3i_job_t wr_word_i,
  output logic     rd_valid_o,
  input  logic     rd_stall_i,
  output m3i_job_t rd_word_o
);

  m3i_job_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_q, rp_q;
  logic [FIFO_AW:0]     cnt_q;
  logic                 wr, rd;

  assign wr_stall_o = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign wr         = wr_valid_i && !wr_stall_o;
  assign rd         = rd_valid_o && !rd_stall_i;
  assign rd_word_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      if (wr && !rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_word_i;
  end

endmodule

>>> design/m3i_back.sv
// m3i_back: pipelined restoring divider, one quotient bit per stage for all
// nine lanes (rounding set up in the numerator), then saturation into the output register. Depends on m3i_pkg.
module m3i_back import m3i_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  output logic     job_stall_o,
  input  m3i_job_t job_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output m3i_out_t out_word_o
);

  logic                 en;
  logic [QW:0]          v_q;
  logic                 ov_q;
  m3i_out_t             out_q, out_d;

  logic [RW-1:0]        rem_q [QW][NLANE];
  logic [QW-1:0]        quo_q [QW+1][NLANE];
  logic [NLANE-1:0]     neg_q [QW+1];
  logic [NLANE-1:0]     ovf_q [QW+1];
  logic [DNW-1:0]       den_q [QW];
  logic                 sing_q [QW+1];

  logic [CW-1:0]        cabs [NLANE];
  logic [RW-1:0]        num [NLANE];
  logic [DNW-1:0]       den;
  logic [QW-1:0]        b [NLANE];
  logic [NLANE-1:0]     sat;

  // pipeline advances whenever the output register can take a word
  assign en          = !ov_q || !out_stall_i;
  assign job_stall_o = !en;
  assign out_valid_o = ov_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else if (en) begin
      v_q  <= {v_q[QW-1:0], job_valid_i};
      ov_q <= v_q[QW];
    end
  end

  // numerator 2*|adj|*2^2F + |det|, divisor 2*|det|: rounds half away from zero
  always_comb begin
    den = {job_i.det_abs, 1'b0};
    for (int l = 0; l < NLANE; l++) begin
      cabs[l] = job_i.cof[l][CW-1] ? (~job_i.cof[l] + 1'b1) : job_i.cof[l];
      num[l]  = (RW'(cabs[l]) << (2 * FRAC_BITS + 1)) + RW'(job_i.det_abs);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q[0]  <= den;
      sing_q[0] <= job_i.singular;
      for (int l = 0; l < NLANE; l++) begin
        rem_q[0][l]  <= num[l];
        quo_q[0][l]  <= '0;
        neg_q[0][l]  <= job_i.cof[l][CW-1] ^ job_i.det_neg;
        // quotient of 2^QW or more saturates in any case
        ovf_q[0][l]  <= num[l] >= (RW'(den) << QW);
      end
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int SH = QW - k;
    logic [RW-1:0] trial;
    logic [NLANE-1:0] ge;
    logic [QW-1:0] qn [NLANE];

    always_comb begin
      trial = RW'(den_q[k-1]) << SH;
      for (int l = 0; l < NLANE; l++) begin
        ge[l]     = rem_q[k-1][l] >= trial;
        qn[l]     = quo_q[k-1][l];
        qn[l][SH] = ge[l];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sing_q[k] <= sing_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        for (int l = 0; l < NLANE; l++) begin
          quo_q[k][l] <= qn[l];
        end
      end
    end

    if (k < QW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en) begin
          den_q[k] <= den_q[k-1];
          for (int l = 0; l < NLANE; l++) begin
            rem_q[k][l] <= ge[l] ? (rem_q[k-1][l] - trial) : rem_q[k-1][l];
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      if (neg_q[QW][l]) begin
        sat[l] = ovf_q[QW][l] || (quo_q[QW][l] > ELEM_MIN);
        b[l]   = sat[l] ? ELEM_MIN : (~quo_q[QW][l] + 1'b1);
      end else begin
        sat[l] = ovf_q[QW][l] || quo_q[QW][l][QW-1];
        b[l]   = sat[l] ? ELEM_MAX : quo_q[QW][l];
      end
      if (sing_q[QW]) begin
        b[l] = '0;
      end
    end
    out_d.b00       = b[0];
    out_d.b01       = b[1];
    out_d.b02       = b[2];
    out_d.b10       = b[3];
    out_d.b11       = b[4];
    out_d.b12       = b[5];
    out_d.b20       = b[6];
    out_d.b21       = b[7];
    out_d.b22       = b[8];
    out_d.singular  = sing_q[QW];
    out_d.saturated = !sing_q[QW] && (|sat);
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

endmodule

>>> design/matrix3x3_inverse.sv
// matrix3x3_inverse: 3x3 Q16.16 inverse by adjugate over determinant.
// Path from input accept to output valid: 5 front stages (the first loads on the
// accept edge), the job queue, one divider setup stage,
// 32 quotient-bit stages, one output register.
// Throughput one word per cycle while out_stall_i is low; the divider pipeline produces one bit per stage.
// Reset clears all valid state and sets the zero threshold (thr_q) to 0.
module matrix3x3_inverse import m3i_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  m3i_in_t              in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output m3i_out_t             out_word_o,
  input  logic                 cfg_we_i,
  input  logic [THR_WIDTH-1:0] cfg_wdata_i
);

  logic [THR_WIDTH-1:0] thr_q;
  logic                 fj_valid, fj_stall, bj_valid, bj_stall;
  m3i_job_t             fj_word, bj_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  m3i_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .thr_i       (thr_q),
    .job_valid_o (fj_valid),
    .job_stall_i (fj_stall),
    .job_o       (fj_word)
  );

  m3i_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fj_valid),
    .wr_stall_o (fj_stall),
    .wr_word_i  (fj_word),
    .rd_valid_o (bj_valid),
    .rd_stall_i (bj_stall),
    .rd_word_o  (bj_word)
  );

  m3i_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bj_valid),
    .job_stall_o (bj_stall),
    .job_i       (bj_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
